[hdl/dfr_pkg.sv]
// Shared types and constants for the length-framed byte deframer.
package dfr_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 16;
  localparam int unsigned KindW = 2;

  localparam logic [ByteW-1:0] SYNC_BYTE = 8'hFE;
  localparam logic [ByteW-1:0] END_BYTE  = 8'h0A;

  // Parser phases; the two unused codes fall back to hunting.
  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_LEN_LO  = 3'd1,
    PH_LEN_HI  = 3'd2,
    PH_TYPE    = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_END     = 3'd5
  } dfr_phase_e;

  // Result kinds carried on the output tuser.
  typedef enum logic [KindW-1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_END_GOOD = 2'd1,
    KIND_END_BAD  = 2'd2
  } dfr_kind_e;

  // One result item as produced by the parser.
  typedef struct packed {
    dfr_kind_e          kind;
    logic [ByteW-1:0]   data_byte;
    logic [ByteW-1:0]   message_type;
    logic [LenW-1:0]    payload_length;
    logic               last_payload;
  } dfr_result_t;

endpackage

[hdl/dfr_in_stage.sv]
// Input register stage that holds one received byte for the parser.
module dfr_in_stage
  import dfr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [ByteW-1:0] byte_i,
  output logic             valid_o,
  input  logic             take_i,
  output logic [ByteW-1:0] byte_o
);

  logic             valid_q, valid_d;
  logic [ByteW-1:0] byte_q;

  // The register frees up in the same cycle its content is consumed.
  assign ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register, loaded on every accepted transaction.
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      byte_q <= byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

[hdl/dfr_parser.sv]
// Frame parser: phase register, header fields and payload down-counter.
module dfr_parser
  import dfr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [ByteW-1:0] byte_i,
  output logic             res_valid_o,
  output dfr_result_t      res_o
);

  dfr_phase_e      phase_q, phase_d;
  logic [LenW-1:0] frame_length_q, frame_length_d;
  logic [ByteW-1:0] frame_type_q, frame_type_d;
  logic [LenW-1:0] bytes_left_q, bytes_left_d;
  logic            last_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_HUNT;
      frame_length_q <= '0;
      frame_type_q   <= '0;
      bytes_left_q   <= '0;
    end else begin
      phase_q        <= phase_d;
      frame_length_q <= frame_length_d;
      frame_type_q   <= frame_type_d;
      bytes_left_q   <= bytes_left_d;
    end
  end

  assign last_byte = (bytes_left_q <= LenW'(1));

  // Next phase and result for the byte in the input register.
  always_comb begin
    phase_d        = phase_q;
    frame_length_d = frame_length_q;
    frame_type_d   = frame_type_q;
    bytes_left_d   = bytes_left_q;
    res_valid_o    = 1'b0;
    res_o.kind           = KIND_PAYLOAD;
    res_o.data_byte      = '0;
    res_o.message_type   = frame_type_q;
    res_o.payload_length = frame_length_q;
    res_o.last_payload   = 1'b0;
    unique case (phase_q)
      PH_HUNT: begin
        if (byte_i == SYNC_BYTE) begin
          phase_d = PH_LEN_LO;
        end
      end
      PH_LEN_LO: begin
        frame_length_d = {{(LenW-ByteW){1'b0}}, byte_i};
        phase_d        = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        frame_length_d = {byte_i, frame_length_q[ByteW-1:0]};
        phase_d        = PH_TYPE;
      end
      PH_TYPE: begin
        frame_type_d = byte_i;
        if (frame_length_q != '0) begin
          bytes_left_d = frame_length_q;
          phase_d      = PH_PAYLOAD;
        end else begin
          phase_d = PH_END;
        end
      end
      PH_PAYLOAD: begin
        if (bytes_left_q != '0) begin
          bytes_left_d = bytes_left_q - LenW'(1);
        end
        if (last_byte) begin
          phase_d = PH_END;
        end
        res_valid_o        = 1'b1;
        res_o.data_byte    = byte_i;
        res_o.last_payload = last_byte;
      end
      PH_END: begin
        phase_d     = PH_HUNT;
        res_valid_o = 1'b1;
        res_o.kind  = (byte_i == END_BYTE) ? KIND_END_GOOD : KIND_END_BAD;
      end
      default: begin
        phase_d = PH_HUNT;
      end
    endcase
    // State only moves when a byte is actually consumed.
    if (!step_i) begin
      phase_d        = phase_q;
      frame_length_d = frame_length_q;
      frame_type_d   = frame_type_q;
      bytes_left_d   = bytes_left_q;
      res_valid_o    = 1'b0;
    end
  end

  // A result is only ever produced from the payload or end phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (phase_q == PH_PAYLOAD || phase_q == PH_END))
    else $error("result outside payload or end phase");

  // A zero-length header goes straight to the end byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && phase_q == PH_TYPE && frame_length_q == '0) |=> phase_q == PH_END)
    else $error("zero length did not skip payload");

  // Each payload byte counts the remaining length down by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && phase_q == PH_PAYLOAD && bytes_left_q > LenW'(1))
    |=> (phase_q == PH_PAYLOAD && bytes_left_q == $past(bytes_left_q) - LenW'(1)))
    else $error("payload counter did not decrement");

endmodule

[hdl/dfr_out_stage.sv]
// Output result register facing the master-side stream.
module dfr_out_stage
  import dfr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  dfr_result_t res_i,
  output logic        ready_o,
  output logic        valid_o,
  input  logic        ready_i,
  output dfr_result_t res_o
);

  logic        valid_q, valid_d;
  dfr_result_t res_q;

  // Free when empty or when the held transaction leaves this cycle.
  assign ready_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = load_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && ready_o) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

  // The last-payload flag only rides on payload results.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && res_q.last_payload) |-> res_q.kind == KIND_PAYLOAD)
    else $error("last flag on a frame-end result");

  // Frame-end results carry a zero data byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && res_q.kind != KIND_PAYLOAD) |-> res_q.data_byte == '0)
    else $error("frame-end result with nonzero data");

endmodule

[hdl/length_framed_byte_deframer.sv]
// Top level of the length-framed byte deframer.
//
//   Channel  Direction  tdata (low bit up)                       tuser   tlast
//   s_axis   in         rx_byte[7:0]                             -       -
//   m_axis   out        data_byte, message_type, payload_length  kind    last_payload
//
// One byte is accepted per cycle while m_axis does not stall. Its result is
// loaded from the input register into the result register, from which it can
// leave on m_axis. The parser works combinationally between the input and
// result registers; its phase, header-field and payload-counter registers
// close its loops. Reset clears the parse phase, header fields, payload
// counter and both valid flags at once. A stall on m_axis holds the result
// register and backs up into the input register and then s_axis tready;
// header bytes give no result but still wait until the result register has room.
module length_framed_byte_deframer
  import dfr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] data_byte, [15:8] message_type,
                                      // [31:16] payload_length
  output logic [1:0]  m_axis_tuser,   // [1:0] result_kind
  output logic        m_axis_tlast    // last_payload
);

  logic             in_valid;
  logic [ByteW-1:0] in_byte;
  logic             out_ready;
  logic             step;
  logic             res_valid;
  dfr_result_t      res;
  dfr_result_t      out_res;

  // A byte is consumed whenever the result register can take its result.
  assign step = in_valid && out_ready;

  dfr_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .byte_i  (s_axis_tdata),
    .valid_o (in_valid),
    .take_i  (out_ready),
    .byte_o  (in_byte)
  );

  dfr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (in_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  dfr_out_stage u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_valid),
    .res_i   (res),
    .ready_o (out_ready),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (out_res)
  );

  // Pack the result onto the master-side stream.
  assign m_axis_tdata = {out_res.payload_length, out_res.message_type, out_res.data_byte};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.last_payload;

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench that streams framed and stray bytes into the deframer and checks results.
module tb;
  import dfr_pkg::*;

  localparam int unsigned ClkHalf     = 10;
  localparam int unsigned ResetCycles = 9;
  localparam int unsigned CycleLimit  = 500000;
  localparam int unsigned RandomItems = 300;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned MaxPrinted  = 40;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [7:0] data_byte, [15:8] message_type,
                               // [31:16] payload_length
  logic [1:0]  m_axis_tuser;   // [1:0] result_kind
  logic        m_axis_tlast;   // last_payload

  // Stimulus controls shared by the sender, the receiver and the tests.
  bit tx_gaps_en;
  bit rx_gaps_en;
  bit hold_req;

  int unsigned mismatch_count;
  int unsigned result_count;
  int unsigned cycle_count;

  // Frame parser mirror and the results it still owes.
  dfr_phase_e  pred_phase;
  logic [15:0] pred_length;
  logic [15:0] pred_left;
  logic [7:0]  pred_type;
  dfr_result_t pending_results[$];

  length_framed_byte_deframer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Free-running clock.
  always #(ClkHalf) clk_i = ~clk_i;

  // Advance the parser mirror by one accepted byte and queue any result it owes.
  function automatic void predict_deframe(input logic [7:0] rx);
    dfr_result_t res;
    logic        is_last;
    res = '0;
    case (pred_phase)
      PH_HUNT: begin
        if (rx == SYNC_BYTE) pred_phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        pred_length = {8'h00, rx};
        pred_phase  = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        pred_length = {rx, pred_length[7:0]};
        pred_phase  = PH_TYPE;
      end
      PH_TYPE: begin
        pred_type = rx;
        if (pred_length != 16'd0) begin
          pred_left  = pred_length;
          pred_phase = PH_PAYLOAD;
        end else begin
          pred_phase = PH_END;
        end
      end
      PH_PAYLOAD: begin
        is_last = (pred_left <= 16'd1);
        if (pred_left != 16'd0) pred_left = pred_left - 16'd1;
        if (is_last) pred_phase = PH_END;
        res.kind           = KIND_PAYLOAD;
        res.data_byte      = rx;
        res.message_type   = pred_type;
        res.payload_length = pred_length;
        res.last_payload   = is_last;
        pending_results.push_back(res);
      end
      PH_END: begin
        pred_phase         = PH_HUNT;
        res.kind           = (rx == END_BYTE) ? KIND_END_GOOD : KIND_END_BAD;
        res.data_byte      = 8'h00;
        res.message_type   = pred_type;
        res.payload_length = pred_length;
        res.last_payload   = 1'b0;
        pending_results.push_back(res);
      end
      default: pred_phase = PH_HUNT;
    endcase
  endfunction

  // Print one line per mismatch, up to a cap, and count every one.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= MaxPrinted) begin
      $display("ERROR %s at result %0d: got 0x%0h, expected 0x%0h",
               what, result_count, got, want);
    end
  endtask

  // Offer one byte, with an optional idle burst first, and wait for the transaction.
  task automatic send_byte(input logic [7:0] rx);
    if (tx_gaps_en && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= 8'($urandom);
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= rx;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_deframe(rx);
    @(negedge clk_i);
  endtask

  // Sync byte, little-endian length and type byte.
  task automatic send_header(input logic [15:0] frame_len, input logic [7:0] msg_type);
    send_byte(SYNC_BYTE);
    send_byte(frame_len[7:0]);
    send_byte(frame_len[15:8]);
    send_byte(msg_type);
  endtask

  // Whole frame with random payload and the given end byte.
  task automatic send_frame(input logic [15:0] frame_len, input logic [7:0] msg_type,
                            input logic [7:0] end_byte);
    send_header(frame_len, msg_type);
    for (int i = 0; i < int'(frame_len); i++) send_byte(8'($urandom));
    send_byte(end_byte);
  endtask

  // Stray bytes, empty frames with good and bad ends, short frames at the byte extremes.
  task automatic test_directed();
    send_byte(8'h00);
    send_byte(END_BYTE);
    send_frame(16'h0000, 8'h00, END_BYTE);
    // The bad end byte is a sync value that must not start a new frame.
    send_frame(16'h0000, 8'hFF, SYNC_BYTE);
    send_header(16'h0001, 8'h7E);
    send_byte(8'hFF);
    send_byte(END_BYTE);
    send_header(16'h0002, 8'h55);
    send_byte(8'h00);
    send_byte(8'h80);
    send_byte(8'h0B);
  endtask

  // The receiver holds off long enough for the block to back up into s_axis.
  task automatic test_backpressure();
    s_axis_tvalid <= 1'b0;
    hold_req = 1'b1;
    repeat (2) @(negedge clk_i);
    send_frame(16'd40, 8'($urandom), END_BYTE);
  endtask

  // Mostly well-formed frames with random content, some noise and bad end bytes.
  task automatic test_random_frames();
    int unsigned frame_items;
    int unsigned pick;
    logic [15:0] frame_len;
    logic [7:0]  end_byte;
    logic [7:0]  rx;
    frame_items = 0;
    while (frame_items < RandomItems) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        // Noise while hunting; a sync value here would open a frame of random length.
        repeat ($urandom_range(1, 4)) begin
          rx = 8'($urandom);
          if (rx == SYNC_BYTE) rx = ~rx;
          send_byte(rx);
        end
      end else begin
        frame_len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(13, 300))
                                                : 16'($urandom_range(0, 12));
        if (pick == 1) end_byte = 8'($urandom);
        else if (pick == 2) end_byte = SYNC_BYTE;
        else end_byte = END_BYTE;
        send_frame(frame_len, 8'($urandom), end_byte);
        frame_items += frame_len + 5;
      end
    end
  endtask

  // No idling from here on: a few short frames, then a header with the largest
  // length and the start of its payload; the run ends inside that frame.
  task automatic test_long_frame();
    tx_gaps_en = 1'b0;
    rx_gaps_en = 1'b0;
    repeat (10) send_frame(16'($urandom_range(0, 12)), 8'($urandom), END_BYTE);
    send_header(16'hFFFF, 8'hA5);
    repeat (40) send_byte(8'($urandom));
  endtask

  // Result receiver: random stalls, plus one long hold-off counted here.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        for (int n = 1; n < HoldCycles; n++) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (rx_gaps_en && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 7)) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Compare every result transaction with the oldest expectation.
  always @(posedge clk_i) begin
    dfr_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, kind", {30'd0, m_axis_tuser}, 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tuser !== want.kind)
          report_mismatch("result_kind", {30'd0, m_axis_tuser}, {30'd0, want.kind});
        if (m_axis_tdata[7:0] !== want.data_byte)
          report_mismatch("data_byte", {24'd0, m_axis_tdata[7:0]}, {24'd0, want.data_byte});
        if (m_axis_tdata[15:8] !== want.message_type)
          report_mismatch("message_type", {24'd0, m_axis_tdata[15:8]},
                          {24'd0, want.message_type});
        if (m_axis_tdata[31:16] !== want.payload_length)
          report_mismatch("payload_length", {16'd0, m_axis_tdata[31:16]},
                          {16'd0, want.payload_length});
        if (m_axis_tlast !== want.last_payload)
          report_mismatch("last_payload", {31'd0, m_axis_tlast}, {31'd0, want.last_payload});
      end
      result_count++;
    end
  end

  // Hard stop if the run hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results pending",
               cycle_count, pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Reset, run the tests in turn, drain and judge.
  initial begin
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = 8'h00;
    tx_gaps_en     = 1'b1;
    rx_gaps_en     = 1'b1;
    hold_req       = 1'b0;
    mismatch_count = 0;
    result_count   = 0;
    cycle_count    = 0;
    pred_phase     = PH_HUNT;
    pred_length    = 16'd0;
    pred_left      = 16'd0;
    pred_type      = 8'h00;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_backpressure();
    test_random_frames();
    test_long_frame();
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
